### sv/lcpe_pkg.sv
// Shared types, constants and draw tables for the LED confetti particle engine.
// No dependencies; every other file imports this package.
`default_nettype none

package lcpe_pkg;

   // Slot storage
   localparam int NUM_PARTICLES = 16;
   localparam int SLOT_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_PARTICLES - 1);

   // Item function codes
   localparam logic FUNC_TRIGGER = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Generator
   localparam logic [30:0] LCG_MULT = 31'd1103515245;
   localparam logic [30:0] LCG_INC  = 31'd12345;

   // Draw kinds, in launch order
   localparam logic [2:0] DRAW_X   = 3'd0;
   localparam logic [2:0] DRAW_Y   = 3'd1;
   localparam logic [2:0] DRAW_VX  = 3'd2;
   localparam logic [2:0] DRAW_VY  = 3'd3;
   localparam logic [2:0] DRAW_HUE = 3'd4;
   localparam logic [2:0] DRAW_SAT = 3'd5;

   // Remainder by reciprocal: q = (v * floor(2^24 / m)) >> 24 is q or q-1 for v < 2^15
   localparam int DRAW_SHIFT = 24;
   localparam int RECIP_W    = 22;
   localparam logic [RECIP_W-1:0] RECIP_6   = RECIP_W'((1 << DRAW_SHIFT) / 6);
   localparam logic [RECIP_W-1:0] RECIP_12  = RECIP_W'((1 << DRAW_SHIFT) / 12);
   localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'((1 << DRAW_SHIFT) / 255);
   localparam logic [RECIP_W-1:0] RECIP_55  = RECIP_W'((1 << DRAW_SHIFT) / 55);

   // Launch constants
   localparam logic signed [15:0] INIT_VX_MIN = -16'sd12;
   localparam logic signed [15:0] INIT_VY_MIN = -16'sd20;
   localparam logic [7:0] LAUNCH_X_BASE = 8'd6;
   localparam logic [7:0] SAT_BASE      = 8'd200;
   localparam logic [7:0] BRIGHT_FULL   = 8'd255;
   localparam logic [7:0] BRIGHT_MIN    = 8'd20;
   localparam logic [6:0] LED_MAX       = 7'd71;

   typedef struct packed {
      logic        func;
      logic [15:0] seed;
   } req_type;

   typedef struct packed {
      logic [3:0] slot;
      logic       lit;
      logic [6:0] led_index;
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] value;
      logic       running;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [7:0]         hue;
      logic [7:0]         sat;
      logic [7:0]         bright;
   } particle_type;

   typedef struct packed {
      logic              valid;
      logic              alive;
      logic              running;
      logic              last;
      logic [SLOT_W-1:0] slot;
   } slot_ctl_type;

   typedef struct packed {
      logic              en;
      logic              alive;
      logic [SLOT_W-1:0] addr;
      particle_type      data;
   } mem_wr_type;

   typedef struct packed {
      logic        load;
      logic        go;
      logic [2:0]  kind;
      logic [15:0] seed;
   } rng_cmd_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } rng_rsp_type;

   function automatic logic [7:0] draw_bound(input logic [2:0] kind);
      logic [7:0] m;
      unique case (kind)
         DRAW_X, DRAW_Y, DRAW_VX: m = 8'd6;
         DRAW_VY:                 m = 8'd12;
         DRAW_HUE:                m = 8'd255;
         DRAW_SAT:                m = 8'd55;
         default:                 m = 8'd6;
      endcase
      return m;
   endfunction

   function automatic logic [RECIP_W-1:0] draw_recip(input logic [2:0] kind);
      logic [RECIP_W-1:0] r;
      unique case (kind)
         DRAW_X, DRAW_Y, DRAW_VX: r = RECIP_6;
         DRAW_VY:                 r = RECIP_12;
         DRAW_HUE:                r = RECIP_255;
         DRAW_SAT:                r = RECIP_55;
         default:                 r = RECIP_6;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/led_confetti_particle_engine_core.sv
// Top level of the LED confetti particle engine: sequencer, particle memory, alive bits.
// Depends on lcpe_pkg, lcpe_rng and lcpe_physics.
`default_nettype none

// A trigger item (func 0) seeds the generator with the 16-bit seed and launches
// NUM_PARTICLES particles on the right hand; it produces no results and keeps busy
// high throughout. Each slot takes six draws through the generator and its reciprocal
// remainder unit, then a store and a restart. A tick item (func 1) while the effect
// runs walks the particle memory one slot per cycle and emits exactly NUM_PARTICLES
// results on consecutive cycles, each passing the read register, the stage-1 register
// and the result register, with last set on the final slot; busy stays high until the
// last slot leaves stage 1. A tick while the effect is off is accepted and gives
// nothing. Results cannot be held off: rsp_valid marks each result for exactly one
// cycle. running is low on the tick that finds no live particle, after which ticks
// are ignored until the next trigger.
module led_confetti_particle_engine_core import lcpe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAW  = 2'd1;  // drawing fields of one new particle
   localparam logic [1:0] ST_STORE = 2'd2;  // writing the new particle
   localparam logic [1:0] ST_TICK  = 2'd3;  // issuing one memory read per slot

   logic [1:0]               state_ff, state_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [2:0]               draw_ff, draw_in;
   logic                     issue_ff, issue_in;
   logic                     effect_on_ff, effect_on_in;
   logic                     running_ff, running_in;
   logic [NUM_PARTICLES-1:0] alive_ff, alive_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [SLOT_W-1:0]        rd_slot_ff;
   particle_type             new_part_ff, new_part_in;
   particle_type             rd_data_ff;

   particle_type part_mem [NUM_PARTICLES];

   logic         accept;
   logic         launch_we;
   logic         mem_we;
   logic [SLOT_W-1:0] mem_addr;
   particle_type mem_wdata;

   rng_cmd_type  rng_cmd;
   rng_rsp_type  rng_rsp;
   slot_ctl_type phys_ctl;
   mem_wr_type   phys_wr;
   logic         phys_busy;

   assign busy   = (state_ff != ST_IDLE) | rd_valid_ff | phys_busy;
   assign accept = start & ~busy;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      draw_in      = draw_ff;
      issue_in     = issue_ff;
      effect_on_in = effect_on_ff;
      running_in   = running_ff;
      alive_in     = alive_ff;
      new_part_in  = new_part_ff;
      rd_valid_in  = 1'b0;
      launch_we    = 1'b0;
      rng_cmd      = '0;
      rng_cmd.kind = draw_ff;
      rng_cmd.seed = req_data.seed;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_TRIGGER) begin
                  rng_cmd.load = 1'b1;
                  effect_on_in = 1'b1;
                  slot_in      = '0;
                  draw_in      = DRAW_X;
                  issue_in     = 1'b1;
                  state_in     = ST_DRAW;
               end else if (effect_on_ff) begin
                  // running reflects whether anything was alive at frame start
                  running_in   = |alive_ff;
                  effect_on_in = |alive_ff;
                  slot_in      = '0;
                  state_in     = ST_TICK;
               end
            end
         end
         ST_DRAW: begin
            rng_cmd.go = issue_ff;
            issue_in   = 1'b0;
            if (rng_rsp.done) begin
               unique case (draw_ff)
                  DRAW_X: begin
                     new_part_in.pos_x  = {4'd0, rng_rsp.value + LAUNCH_X_BASE, 4'd0};
                     new_part_in.bright = BRIGHT_FULL;
                  end
                  DRAW_Y:   new_part_in.pos_y = {4'd0, rng_rsp.value, 4'd0};
                  DRAW_VX:  new_part_in.vel_x = $signed({8'd0, rng_rsp.value}) + INIT_VX_MIN;
                  DRAW_VY:  new_part_in.vel_y = $signed({8'd0, rng_rsp.value}) + INIT_VY_MIN;
                  DRAW_HUE: new_part_in.hue   = rng_rsp.value;
                  DRAW_SAT: new_part_in.sat   = rng_rsp.value + SAT_BASE;
                  default: ;
               endcase
               if (draw_ff == DRAW_SAT) begin
                  state_in = ST_STORE;
               end else begin
                  // chain the next draw straight away
                  draw_in      = draw_ff + 3'd1;
                  rng_cmd.go   = 1'b1;
                  rng_cmd.kind = draw_ff + 3'd1;
               end
            end
         end
         ST_STORE: begin
            launch_we         = 1'b1;
            alive_in[slot_ff] = 1'b1;
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               draw_in  = DRAW_X;
               issue_in = 1'b1;
               state_in = ST_DRAW;
            end
         end
         ST_TICK: begin
            rd_valid_in = 1'b1;
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Write-back of a slot two reads behind the current one; never the same entry.
      if (phys_wr.en) begin
         alive_in[phys_wr.addr] = phys_wr.alive;
      end
   end

   // Launch and write-back never overlap in time.
   assign mem_we    = launch_we | phys_wr.en;
   assign mem_addr  = launch_we ? slot_ff : phys_wr.addr;
   assign mem_wdata = launch_we ? new_part_ff : phys_wr.data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         part_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= part_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         draw_ff      <= DRAW_X;
         issue_ff     <= 1'b0;
         effect_on_ff <= 1'b0;
         running_ff   <= 1'b0;
         alive_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         draw_ff      <= draw_in;
         issue_ff     <= issue_in;
         effect_on_ff <= effect_on_in;
         running_ff   <= running_in;
         alive_ff     <= alive_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_part_ff <= new_part_in;
      rd_slot_ff  <= slot_ff;
   end

   lcpe_rng u_rng (
      .clock (clock),
      .reset (reset),
      .cmd   (rng_cmd),
      .rsp   (rng_rsp)
   );

   assign phys_ctl.valid   = rd_valid_ff;
   assign phys_ctl.alive   = alive_ff[rd_slot_ff];
   assign phys_ctl.running = running_ff;
   assign phys_ctl.last    = (rd_slot_ff == LAST_SLOT);
   assign phys_ctl.slot    = rd_slot_ff;

   lcpe_physics u_physics (
      .clock     (clock),
      .reset     (reset),
      .ctl       (phys_ctl),
      .cur       (rd_data_ff),
      .wr        (phys_wr),
      .busy      (phys_busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Results only come out of a tick that was still in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("core: result without work in flight");

   // The last slot of a frame is followed by a gap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("core: result right after last slot");

   // The generator is only started while launching.
   assert property (@(posedge clock) disable iff (reset)
      rng_cmd.go |-> (state_ff == ST_DRAW))
      else $error("core: draw outside launch");

endmodule

`default_nettype wire

### sv/lcpe_rng.sv
// 31-bit linear congruential generator with a bounded draw (remainder by reciprocal).
// Depends on lcpe_pkg.
`default_nettype none

module lcpe_rng import lcpe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rng_cmd_type cmd,
   output rng_rsp_type      rsp
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_QUO  = 2'd1;
   localparam logic [1:0] PH_REM  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [30:0] gen_ff, gen_in;
   logic [2:0]  kind_ff, kind_in;
   logic [14:0] v_ff, v_in;
   logic [14:0] q_ff, q_in;
   logic        done_ff, done_in;
   logic [7:0]  value_ff, value_in;

   logic [36:0] prod;
   logic [14:0] rem;
   logic [14:0] bound15;

   always_comb begin
      phase_in = phase_ff;
      gen_in   = gen_ff;
      kind_in  = kind_ff;
      v_in     = v_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      bound15  = {7'd0, draw_bound(kind_ff)};
      prod     = 37'(gen_ff[30:16]) * 37'(draw_recip(kind_ff));
      rem      = v_ff - 15'(q_ff * bound15);
      if (rem >= bound15) begin
         rem = rem - bound15;
      end

      if (cmd.load) begin
         gen_in = {15'd0, cmd.seed};
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd.go) begin
               gen_in   = gen_ff * LCG_MULT + LCG_INC;
               kind_in  = cmd.kind;
               phase_in = PH_QUO;
            end
         end
         PH_QUO: begin
            v_in     = gen_ff[30:16];
            q_in     = 15'(prod >> DRAW_SHIFT);
            phase_in = PH_REM;
         end
         PH_REM: begin
            value_in = 8'(rem);
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         gen_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         gen_ff   <= gen_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      v_ff     <= v_in;
      q_ff     <= q_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

   // A draw result always lies below the bound of its kind.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({7'd0, value_ff} < {7'd0, draw_bound(kind_ff)}))
      else $error("lcpe_rng: draw out of range");

endmodule

`default_nettype wire

### sv/lcpe_physics.sv
// Two-stage per-slot update: move with gravity, then bounces, fading, death and LED mapping.
// Depends on lcpe_pkg; fed from the particle memory read port.
`default_nettype none

module lcpe_physics import lcpe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire slot_ctl_type ctl,
   input  wire particle_type cur,
   output mem_wr_type        wr,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam logic signed [15:0] GRAVITY = 16'sd2;
   localparam logic signed [15:0] FLOOR_Y = 16'sd80;   // row 5 in 1/16 units
   localparam logic signed [15:0] WALL_X  = 16'sd176;  // column 11
   localparam logic [7:0] FLOOR_FADE = 8'd30;
   localparam logic [7:0] WALL_FADE  = 8'd40;
   localparam logic [3:0] COL_MAX    = 4'd11;
   localparam logic [3:0] HALF_W     = 4'd6;
   localparam logic [2:0] ROW_MAX    = 3'd5;
   localparam logic [6:0] ROW_LEDS   = 7'd6;
   localparam logic [6:0] RIGHT_OFS  = 7'd30;  // 36 minus the 6 columns of the left hand

   function automatic logic signed [15:0] half_trunc(input logic signed [15:0] v);
      logic [16:0] t;
      t = {v[15], v} + {16'd0, v[15]};
      return t[16:1];
   endfunction

   function automatic logic signed [15:0] neg_half(input logic signed [15:0] v);
      logic [16:0] n;
      logic [16:0] t;
      n = 17'd0 - {v[15], v};
      t = n + {16'd0, n[16]};
      return t[16:1];
   endfunction

   function automatic logic slow(input logic signed [15:0] v);
      return (v >= -16'sd1) && (v <= 16'sd1);
   endfunction

   slot_ctl_type s1_ctl_ff, s1_ctl_in;
   particle_type s1_part_ff, s1_part_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;

   particle_type p;
   logic         die;
   logic         lit;
   logic signed [11:0] lx, ly;
   logic [3:0]   lxc;
   logic [2:0]   lyc;
   logic [6:0]   led;

   // Stage 1: gravity and motion
   always_comb begin
      s1_ctl_in        = ctl;
      s1_part_in       = cur;
      s1_part_in.vel_y = cur.vel_y + GRAVITY;
      s1_part_in.pos_x = cur.pos_x + cur.vel_x;
      s1_part_in.pos_y = cur.pos_y + s1_part_in.vel_y;
   end

   // Stage 2: collisions and fate
   always_comb begin
      p   = s1_part_ff;
      die = 1'b0;
      lx  = s1_part_ff.pos_x[15:4];
      ly  = s1_part_ff.pos_y[15:4];

      if (p.pos_y >= FLOOR_Y) begin
         p.pos_y = FLOOR_Y;
         p.vel_y = neg_half(p.vel_y);
         p.vel_x = half_trunc(p.vel_x);
         if (p.bright > FLOOR_FADE) begin
            p.bright = p.bright - FLOOR_FADE;
         end else begin
            die = 1'b1;
         end
      end
      if (!die && p.pos_x[15]) begin
         p.pos_x = '0;
         p.vel_x = '0;
         if (p.bright > WALL_FADE) begin
            p.bright = p.bright - WALL_FADE;
         end else begin
            die = 1'b1;
         end
      end
      if (!die && (p.pos_x >= WALL_X)) begin
         p.pos_x = WALL_X;
         p.vel_x = neg_half(p.vel_x);
      end
      if (!die && p.pos_y[15]) begin
         p.pos_y = '0;
         p.vel_y = neg_half(p.vel_y);
      end
      if (!die && ((p.bright < BRIGHT_MIN) || (slow(p.vel_x) && slow(p.vel_y)))) begin
         die = 1'b1;
      end
      lit = s1_ctl_ff.alive && !die;

      // LED from the moved position, clamped to the field
      if (lx[11]) begin
         lxc = '0;
      end else if (lx[10:0] > {7'd0, COL_MAX}) begin
         lxc = COL_MAX;
      end else begin
         lxc = lx[3:0];
      end
      if (ly[11]) begin
         lyc = '0;
      end else if (ly[10:0] > {8'd0, ROW_MAX}) begin
         lyc = ROW_MAX;
      end else begin
         lyc = ly[2:0];
      end
      led = 7'(lyc) * ROW_LEDS + 7'(lxc);
      if (lxc >= HALF_W) begin
         led = led + RIGHT_OFS;
      end

      rsp_in.slot       = 4'(s1_ctl_ff.slot);
      rsp_in.lit        = lit;
      rsp_in.led_index  = lit ? led : '0;
      rsp_in.hue        = lit ? p.hue : '0;
      rsp_in.saturation = lit ? p.sat : '0;
      rsp_in.value      = lit ? p.bright : '0;
      rsp_in.running    = s1_ctl_ff.running;
      rsp_in.last       = s1_ctl_ff.last;
   end

   // Dead slots are written too; their contents are overwritten on the next launch.
   assign wr.en    = s1_ctl_ff.valid;
   assign wr.alive = lit;
   assign wr.addr  = s1_ctl_ff.slot;
   assign wr.data  = p;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff    <= s1_ctl_in;
         rsp_valid_ff <= s1_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_part_ff <= s1_part_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = s1_ctl_ff.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A drawn particle is bright enough and maps onto the matrix.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.lit) |-> ((rsp_ff.value >= BRIGHT_MIN) &&
                                        (rsp_ff.led_index <= LED_MAX)))
      else $error("lcpe_physics: lit item out of range");

endmodule

`default_nettype wire
